// ----- hw/rtl/rfpf_pkg.sv -----
`timescale 1ns / 1ps
package rfpf_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned BaseW  = 17;
  localparam int unsigned ResW   = 16;
  localparam int unsigned CutW   = 16;
  localparam int unsigned FracW  = 16;
  localparam int unsigned QuoW   = 23;
  localparam int unsigned FbW    = 24;
  localparam int unsigned McandW = 43;
  localparam int unsigned AccW   = McandW + 1;
  localparam int unsigned SumW   = AccW + 1;
  localparam int unsigned StepW  = 5;

  localparam logic [CutW-1:0]  CutMin   = 16'd655;
  localparam logic [CutW-1:0]  CutMax   = 16'd64881;
  localparam logic [BaseW-1:0] BaseRst  = 17'd32768;
  localparam logic [ResW-1:0]  ResRst   = 16'd32768;
  localparam logic [StepW-1:0] FbSteps  = 5'd24;
  localparam logic [StepW-1:0] CutSteps = 5'd16;
  localparam logic [StepW-1:0] DivSteps = 5'd23;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FB,
    ST_POLE,
    ST_OUT
  } state_e;

  typedef enum logic [0:0] {
    REG_BASE_CUTOFF,
    REG_RESONANCE
  } cfg_reg_e;

  typedef struct packed {
    logic                     start;
    logic signed [McandW-1:0] mcand;
    logic [FbW-1:0]           mplier;
    logic [StepW-1:0]         steps;
  } mul_req_t;

  typedef struct packed {
    logic            start;
    logic [ResW-1:0] res;
    logic [CutW-1:0] divisor;
  } div_req_t;

  localparam logic signed [SumW-1:0] SatMax = SumW'(signed'(32'h7fff_ffff));
  localparam logic signed [SumW-1:0] SatMin = SumW'(signed'(32'h8000_0000));

  function automatic logic signed [DataW-1:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > SatMax) begin
      r = SatMax[DataW-1:0];
    end else if (v < SatMin) begin
      r = SatMin[DataW-1:0];
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/rfpf_div.sv -----
`timescale 1ns / 1ps
module rfpf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rfpf_pkg::div_req_t          req_i,
  output logic [rfpf_pkg::QuoW-1:0]   quo_o,
  output logic                        done_o
);
  import rfpf_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [CutW-1:0]  rem_q, rem_d;
  logic [CutW-1:0]  dvs_q, dvs_d;
  logic [QuoW-1:0]  qd_q, qd_d;
  logic [CutW:0]    trial;
  logic             ge;

  always_comb begin
    trial  = {rem_q, qd_q[QuoW-1]};
    ge     = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    qd_d   = qd_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivSteps;
      rem_d  = CutW'(req_i.res[ResW-1:QuoW-FracW]);
      qd_d   = {req_i.res[QuoW-FracW-1:0], FracW'(0)};
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? CutW'(trial - {1'b0, dvs_q}) : trial[CutW-1:0];
      qd_d  = {qd_q[QuoW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    qd_q  <= qd_d;
  end

  assign quo_o  = qd_q;
  assign done_o = done_q;

endmodule

// ----- hw/rtl/rfpf_mul.sv -----
`timescale 1ns / 1ps
module rfpf_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rfpf_pkg::mul_req_t                req_i,
  output logic signed [rfpf_pkg::AccW-1:0]  hi_o,
  output logic [rfpf_pkg::FbW-1:0]          lo_o,
  output logic                              done_o
);
  import rfpf_pkg::*;

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [StepW-1:0]         cnt_q, cnt_d;
  logic signed [McandW-1:0] mcand_q, mcand_d;
  logic [FbW-1:0]           mplier_q, mplier_d;
  logic signed [AccW-1:0]   hi_q, hi_d;
  logic [FbW-1:0]           lo_q, lo_d;
  logic signed [AccW-1:0]   addend;
  logic signed [AccW-1:0]   sum;

  always_comb begin
    addend   = mplier_q[0] ? AccW'(mcand_q) : AccW'(0);
    sum      = hi_q + addend;
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    hi_d     = hi_q;
    lo_d     = lo_q;
    if (req_i.start) begin
      busy_d   = 1'b1;
      cnt_d    = req_i.steps;
      mcand_d  = req_i.mcand;
      mplier_d = req_i.mplier;
      hi_d     = '0;
      lo_d     = '0;
    end else if (busy_q) begin
      hi_d     = sum >>> 1;
      lo_d     = {sum[0], lo_q[FbW-1:1]};
      mplier_d = {1'b0, mplier_q[FbW-1:1]};
      cnt_d    = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
  end

  assign hi_o   = hi_q;
  assign lo_o   = lo_q;
  assign done_o = done_q;

endmodule

// ----- hw/rtl/resonant_four_pole_filter.sv -----
`timescale 1ns / 1ps
// Four cascaded one-pole stages with resonance feedback into the first stage,
// Q15.16 samples in and lowpass, bandpass and highpass out. From acceptance
// to a result in the output register, a restoring divider finds the feedback
// gain one quotient bit per cycle, then a single shift-add multiplier, one
// multiplier bit per cycle, forms the feedback product and the four stage
// products, with a handover between operations, and the output register is
// loaded once the previous result has been taken downstream. The next item
// can be taken as soon as the result sits in the output register, even if it
// is not yet taken downstream, so an item is accepted only once the previous
// one has reached the output register. Write configuration only while
// no item is in flight.
module resonant_four_pole_filter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // audio_in [31:0], cutoff_mod [63:32]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // lowpass_out [31:0], bandpass_out [63:32],
                                       // highpass_out [95:64]
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [16:0]  cfg_data_i
);
  import rfpf_pkg::*;

  state_e                  state_q, state_d;
  logic [1:0]              k_q, k_d;
  logic [BaseW-1:0]        base_q;
  logic [ResW-1:0]         res_q;
  logic [CutW-1:0]         cut_q, cut_d;
  logic signed [DataW-1:0] x_q, x_d;
  logic signed [DataW-1:0] s1_q, s1_d, s2_q, s2_d, s3_q, s3_d, s4_q, s4_d;
  logic signed [DataW-1:0] lp_q, lp_d, bp_q, bp_d, hp_q, hp_d;
  logic                    m_valid_q, m_valid_d;

  logic                            s_fire;
  logic signed [DataW-1:0]         audio_in;
  logic signed [DataW-1:0]         cutoff_mod;
  logic signed [DataW+1:0]         cut_sum;
  logic [CutW-1:0]                 cut_clamp;
  logic [CutW:0]                   div_full;
  div_req_t                        div_req;
  logic [QuoW-1:0]                 div_quo;
  logic                            div_done;
  mul_req_t                        mul_req;
  logic signed [AccW-1:0]          mul_hi;
  logic [FbW-1:0]                  mul_lo;
  logic                            mul_done;
  logic signed [DataW:0]           diff12;
  logic signed [AccW+FbW-FracW-1:0] fb_prod;
  logic signed [AccW+FbW-FracW-1:0] term;
  logic signed [DataW-1:0]         cur, nxt, upd;

  assign audio_in   = s_axis_tdata[31:0];
  assign cutoff_mod = s_axis_tdata[63:32];
  assign s_fire     = s_axis_tvalid && s_axis_tready;

  assign cut_sum = (DataW+2)'($signed({1'b0, base_q})) + (DataW+2)'(cutoff_mod);

  always_comb begin
    if (cut_sum < (DataW+2)'($signed({1'b0, CutMin}))) begin
      cut_clamp = CutMin;
    end else if (cut_sum > (DataW+2)'($signed({1'b0, CutMax}))) begin
      cut_clamp = CutMax;
    end else begin
      cut_clamp = cut_sum[CutW-1:0];
    end
  end

  assign div_full        = {1'b1, CutW'(0)} - {1'b0, cut_clamp};
  assign div_req.start   = s_fire;
  assign div_req.res     = res_q;
  assign div_req.divisor = div_full[CutW-1:0];

  rfpf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .quo_o  (div_quo),
    .done_o (div_done)
  );

  rfpf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .hi_o   (mul_hi),
    .lo_o   (mul_lo),
    .done_o (mul_done)
  );

  assign diff12  = (DataW+1)'(s1_q) - (DataW+1)'(s2_q);
  assign fb_prod = $signed({mul_hi, mul_lo[FbW-1:FracW]});
  assign term    = fb_prod + (AccW+FbW-FracW)'(x_q) - (AccW+FbW-FracW)'(s1_q);

  always_comb begin
    case (k_q)
      2'd0: begin
        cur = s1_q;
        nxt = s2_q;
      end
      2'd1: begin
        cur = s2_q;
        nxt = s3_q;
      end
      2'd2: begin
        cur = s3_q;
        nxt = s4_q;
      end
      default: begin
        cur = s4_q;
        nxt = s4_q;
      end
    endcase
  end

  assign upd = sat32(SumW'(cur) + SumW'(mul_hi));

  always_comb begin
    state_d        = state_q;
    k_d            = k_q;
    cut_d          = cut_q;
    x_d            = x_q;
    s1_d           = s1_q;
    s2_d           = s2_q;
    s3_d           = s3_q;
    s4_d           = s4_q;
    lp_d           = lp_q;
    bp_d           = bp_q;
    hp_d           = hp_q;
    m_valid_d      = m_valid_q && !m_axis_tready;
    s_axis_tready  = 1'b0;
    mul_req        = '0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          x_d     = audio_in;
          cut_d   = cut_clamp;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = McandW'(diff12);
          mul_req.mplier = FbW'(res_q) + FbW'(div_quo);
          mul_req.steps  = FbSteps;
          state_d        = ST_FB;
        end
      end
      ST_FB: begin
        if (mul_done) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = McandW'(term);
          mul_req.mplier = FbW'(cut_q);
          mul_req.steps  = CutSteps;
          k_d            = 2'd0;
          state_d        = ST_POLE;
        end
      end
      ST_POLE: begin
        if (mul_done) begin
          case (k_q)
            2'd0:    s1_d = upd;
            2'd1:    s2_d = upd;
            2'd2:    s3_d = upd;
            default: s4_d = upd;
          endcase
          if (k_q == 2'd3) begin
            state_d = ST_OUT;
          end else begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = McandW'(upd) - McandW'(nxt);
            mul_req.mplier = FbW'(cut_q);
            mul_req.steps  = CutSteps;
            k_d            = k_q + 2'd1;
          end
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          lp_d      = s4_q;
          bp_d      = sat32(SumW'(s1_q) - SumW'(s4_q));
          hp_d      = sat32(SumW'(x_q) - SumW'(s4_q));
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      m_valid_q <= 1'b0;
      s1_q      <= '0;
      s2_q      <= '0;
      s3_q      <= '0;
      s4_q      <= '0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      m_valid_q <= m_valid_d;
      s1_q      <= s1_d;
      s2_q      <= s2_d;
      s3_q      <= s3_d;
      s4_q      <= s4_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseRst;
      res_q  <= ResRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_BASE_CUTOFF: base_q <= cfg_data_i[BaseW-1:0];
        REG_RESONANCE:   res_q  <= cfg_data_i[ResW-1:0];
        default: begin
          base_q <= base_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cut_q <= cut_d;
    x_q   <= x_d;
    lp_q  <= lp_d;
    bp_q  <= bp_d;
    hp_q  <= hp_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {hp_q, bp_q, lp_q};

`ifndef SYNTHESIS
  a_cut_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (cut_q >= CutMin && cut_q <= CutMax))
    else $error("cutoff coefficient out of range while busy");

  a_fire_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (state_q == ST_DIV))
    else $error("accepted item did not start the divider phase");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divider phase");

  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_FB || state_q == ST_POLE))
    else $error("multiplier finished outside a multiply phase");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import rfpf_pkg::*;

  localparam longint      Unity          = 65536;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned NumPhases      = 7;
  localparam int unsigned RandomPerPhase = 158;
  localparam int unsigned QuietItems     = 120;
  localparam int unsigned DrainCycles    = 150;

  class filter_scoreboard;
    logic [BaseW-1:0] base_cut;
    logic [ResW-1:0]  res_amt;
    longint           stage[4];
    logic [95:0]      expected_bands[$];
    int unsigned      errors;
    int unsigned      samples_noted;
    int unsigned      bands_checked;

    function new();
      base_cut = BaseRst;
      res_amt  = ResRst;
      foreach (stage[k]) stage[k] = 0;
      errors = 0;
      samples_noted = 0;
      bands_checked = 0;
    endfunction

    function void set_registers(logic [16:0] base, logic [16:0] res);
      base_cut = base;
      res_amt  = res[ResW-1:0];
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note_sample(logic signed [31:0] audio, logic signed [31:0] mod);
      longint x, cut, lo, hi, res, gain, term, s1, s2, s4_old, lp, bp, hp;
      x   = longint'(audio);
      cut = longint'(base_cut);
      cut = cut + longint'(mod);
      lo  = longint'(CutMin);
      hi  = longint'(CutMax);
      res = longint'(res_amt);
      s1  = stage[0];
      s2  = stage[1];
      if (cut < lo) cut = lo;
      if (cut > hi) cut = hi;
      gain = res + (res << FracW) / (Unity - cut);
      term = x - s1 + ((gain * (s1 - s2)) >>> FracW);
      stage[0] = clip32(s1 + ((cut * term) >>> FracW));
      for (int k = 1; k < 4; k++) begin
        stage[k] = clip32(stage[k] + ((cut * (stage[k-1] - stage[k])) >>> FracW));
      end
      lp = stage[3];
      bp = clip32(stage[0] - stage[3]);
      hp = clip32(x - stage[3]);
      expected_bands.push_back({32'(hp), 32'(bp), 32'(lp)});
      samples_noted++;
    endfunction

    function void check_bands(logic [95:0] got);
      string       field_name[3] = '{"lowpass", "bandpass", "highpass"};
      logic [95:0] want;
      if (expected_bands.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, got %h", $time, got);
        return;
      end
      want = expected_bands.pop_front();
      bands_checked++;
      for (int k = 0; k < 3; k++) begin
        if (want[32*k +: 32] !== got[32*k +: 32]) begin
          errors++;
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name[k],
                   $signed(want[32*k +: 32]), $signed(got[32*k +: 32]));
        end
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  cfg_reg_e    cfg_idx       = REG_BASE_CUTOFF;
  logic [16:0] cfg_data_i    = '0;

  filter_scoreboard sb;
  bit          quiet       = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;

  resonant_four_pole_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (quiet) begin
      stall_left    <= 0;
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sb.note_sample(s_axis_tdata[31:0], s_axis_tdata[63:32]);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_bands(m_axis_tdata);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_sample(logic signed [31:0] audio, logic signed [31:0] mod);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        while (!s_axis_tready) @(posedge clk_i);
      end
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {mod, audio};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_bands.size() != 0);
  endtask

  task automatic set_filter(logic [16:0] base, logic [16:0] res);
    cfg_we_i   <= 1'b1;
    cfg_idx    <= REG_BASE_CUTOFF;
    cfg_data_i <= base;
    @(posedge clk_i);
    cfg_idx    <= REG_RESONANCE;
    cfg_data_i <= res;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_registers(base, res);
  endtask

  function automatic logic signed [31:0] pick_audio();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 262144) - 131072;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_mod();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 131072) - 65536;
    endcase
  endfunction

  initial begin
    logic [16:0] phase_base [NumPhases];
    logic [16:0] phase_res  [NumPhases];
    sb = new();
    phase_base = '{17'd0, 17'd65536, 17'h1ffff, 17'd32768, 17'd0, 17'd0, 17'd1000};
    phase_res  = '{17'd0, 17'd64880, 17'h1ffff, 17'h10000, 17'd0, 17'd0, 17'd60000};
    for (int p = 4; p < 6; p++) begin
      phase_base[p] = 17'($urandom_range(0, 65536));
      phase_res[p]  = 17'($urandom_range(0, 64880));
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: field extremes and cutoff clamp edges
    send_sample(32'sd0, 32'sd0);
    send_sample(32'sd65536, 32'sd0);
    repeat (3) send_sample(32'h7fff_ffff, 32'sd0);
    repeat (2) send_sample(32'h8000_0000, 32'sd0);
    send_sample(32'h7fff_ffff, 32'h7fff_ffff);
    send_sample(32'h8000_0000, 32'h8000_0000);
    send_sample(32'h1234_5678, -32'sd32114);
    send_sample(-32'sd65536, -32'sd32113);
    send_sample(32'sd65536, 32'sd32113);
    send_sample(32'sd65536, 32'sd32114);
    send_sample(-32'sd1, 32'sd32767);
    send_sample(32'sd1, -32'sd32768);
    send_sample(32'h5555_5555, 32'haaaa_aaaa);
    send_sample(32'haaaa_aaaa, 32'h5555_5555);
    send_sample(32'h7fff_ffff, 32'sd32000);
    send_sample(32'h8000_0000, 32'sd32000);
    send_sample(32'sd0, 32'sd0);

    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      set_filter(phase_base[p], phase_res[p]);
      for (int n = 0; n < RandomPerPhase; n++) begin
        if (p == NumPhases - 1 && n + QuietItems >= RandomPerPhase) quiet = 1'b1;
        send_sample(pick_audio(), pick_mod());
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d samples and checked %0d filter outputs over %0d register settings,",
             sb.samples_noted, sb.bands_checked, NumPhases + 1);
    $display("with random stalls on both sides and a final stretch at full rate.");
    if (sb.errors == 0 && sb.expected_bands.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/rfpf_pkg.sv
hw/rtl/rfpf_div.sv
hw/rtl/rfpf_mul.sv
hw/rtl/resonant_four_pole_filter.sv
test/testbench.sv
